### sv/wtu_pkg.sv
// shared types, codes and sizes of the watchpoint table unit
`timescale 1ns / 1ps
`default_nettype none

package wtu_pkg;

   // table size and the widths that follow from it
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // stream payload widths
   localparam int REQ_DATA_W  = 160;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 216;
   localparam int RSP_USER_W  = 2;

   // operation codes
   typedef enum logic [2:0] {
      OP_SET     = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_CHECK   = 3'd2,
      OP_SUSPEND = 3'd3,
      OP_RESUME  = 3'd4,
      OP_GET     = 3'd5
   } op_type;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // one table entry
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] len;
      logic [15:0] ident;
      logic        rd;
      logic        wr;
      logic [31:0] hits;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // outcome of comparing one entry with the current item
   typedef struct packed {
      logic id_hit;
      logic range_hit;
   } match_type;

   // one result item
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_id;
      logic [4:0]  removed_count;
      logic        halt;
      logic [31:0] entry_address;
      logic [31:0] entry_length;
      logic        entry_on_read;
      logic        entry_on_write;
      logic [31:0] entry_hits;
      logic [31:0] total_hits;
      logic [31:0] hit_value;
      logic [31:0] hit_pc;
   } result_type;

endpackage

`default_nettype wire

### sv/wtu_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module wtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/wtu_match.sv
// shared compare unit: id match and direction / range overlap for one entry
`timescale 1ns / 1ps
`default_nettype none

module wtu_match (
   input  wire wtu_pkg::entry_type entry,
   input  wire logic [31:0]        address,
   input  wire logic [31:0]        access_end,
   input  wire logic               wr_access,
   input  wire logic [15:0]        watch_id,
   output wtu_pkg::match_type      result
);

   import wtu_pkg::*;

   logic [31:0] watch_end;
   logic        dir_ok;

   // end of the watched range, wrapping
   assign watch_end = entry.start + entry.len;

   // direction of the access against the entry's enables
   assign dir_ok = wr_access ? entry.wr : entry.rd;

   // overlap test and id compare
   assign result.range_hit = dir_ok && !((access_end <= entry.start) || (address >= watch_end));
   assign result.id_hit    = (entry.ident == watch_id);

endmodule

`default_nettype wire

### sv/watchpoint_table_unit.sv
// watchpoint table unit: sequencer, entry table and result register
// set, suspend, resume, clear all and unknown codes go from exec to done; get
// reads its entry in a get state first; check and clear by id scan one entry per
// cycle through the shared compare unit, and a clear that finds its id moves the
// last entry into the removed slot by a read and a write state; one item at a
// time, the next taken in the cycle after the output register is loaded.
// reset clears count, suspend and global hits, sets next id to 1; table is kept.
`timescale 1ns / 1ps
`default_nettype none

module watchpoint_table_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: address, length, on_read, wr_enable, watch_id, entry_index,
   // access_size, wr_access, write_value, pc, zero fill
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [wtu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: operation
   input  wire logic [wtu_pkg::REQ_USER_W-1:0]  req_tuser,
   // rsp_tdata: result_id, removed_count, halt, entry_address, entry_length,
   // entry_on_read, entry_on_write, entry_hits, total_hits, hit_value, hit_pc
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [wtu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: status
   output logic      [wtu_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   import wtu_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EXEC    = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_MOVE_RD = 7'b0001000,
      ST_MOVE_WR = 7'b0010000,
      ST_GET     = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   // control state
   state_type        state_ff,  state_in;
   logic [CNT_W-1:0] total_ff,  total_in;
   logic [15:0]      next_id_ff, next_id_in;
   logic [7:0]       susp_ff,   susp_in;
   logic [31:0]      global_ff, global_in;
   logic [CNT_W-1:0] scan_ff,   scan_in;
   logic             ev_ff,     ev_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item and result payload
   op_type      op_ff;
   logic [31:0] addr_ff;
   logic [31:0] len_ff;
   logic        rd_ff;
   logic        wr_ff;
   logic [15:0] wid_ff;
   logic [3:0]  idx_ff;
   logic        isw_ff;
   logic [31:0] val_ff;
   logic [31:0] pc_ff;
   logic [31:0] acc_end_ff;
   result_type  res_ff, res_in;
   result_type  rsp_ff;

   // table port signals
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        ram_rdata;

   logic             accept;
   logic             scan_hit;
   logic             scan_more;
   match_type        match;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // entry table
   wtu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared compare unit, fed by the entry just read
   wtu_match u_match (
      .entry      (ram_rdata),
      .address    (addr_ff),
      .access_end (acc_end_ff),
      .wr_access  (isw_ff),
      .watch_id   (wid_ff),
      .result     (match)
   );

   assign scan_hit  = (op_ff == OP_CHECK) ? match.range_hit : match.id_hit;
   assign scan_more = (scan_ff < total_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      next_id_in   = next_id_ff;
      susp_in      = susp_ff;
      global_in    = global_ff;
      scan_in      = scan_ff;
      ev_in        = ev_ff;
      ev_idx_in    = ev_idx_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            scan_in  = '0;
            ev_in    = 1'b0;
            unique case (op_ff)
               OP_SET: begin
                  if (32'(total_ff) >= 32'(TABLE_DEPTH)) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     ram_we          = 1'b1;
                     ram_waddr       = total_ff[IDX_W-1:0];
                     ram_wdata.start = addr_ff;
                     ram_wdata.len   = (len_ff == 32'd0) ? 32'd1 : len_ff;
                     ram_wdata.ident = next_id_ff;
                     ram_wdata.rd    = rd_ff;
                     ram_wdata.wr    = (!rd_ff && !wr_ff) ? 1'b1 : wr_ff;
                     ram_wdata.hits  = 32'd0;
                     total_in        = total_ff + CNT_W'(1);
                     res_in.result_id = next_id_ff;
                     next_id_in = (next_id_ff == 16'hFFFF) ? 16'd1 : next_id_ff + 16'd1;
                  end
               end
               OP_CLEAR: begin
                  if (wid_ff == 16'd0) begin
                     res_in.removed_count = 5'(total_ff);
                     total_in             = '0;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               OP_CHECK: begin
                  if (susp_ff == 8'd0) begin
                     state_in = ST_SCAN;
                  end
               end
               OP_SUSPEND: begin
                  if (susp_ff != 8'hFF) begin
                     susp_in = susp_ff + 8'd1;
                  end
               end
               OP_RESUME: begin
                  if (susp_ff != 8'd0) begin
                     susp_in = susp_ff - 8'd1;
                  end
               end
               OP_GET: begin
                  if (32'(idx_ff) >= 32'(total_ff)) begin
                     res_in.status = STATUS_RANGE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = IDX_W'(idx_ff);
                     state_in  = ST_GET;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            if (ev_ff && scan_hit) begin
               ev_in = 1'b0;
               if (op_ff == OP_CHECK) begin
                  // count the hit in the entry and globally
                  ram_we            = 1'b1;
                  ram_waddr         = ev_idx_ff;
                  ram_wdata         = ram_rdata;
                  ram_wdata.hits    = ram_rdata.hits + 32'd1;
                  global_in         = global_ff + 32'd1;
                  res_in.result_id  = ram_rdata.ident;
                  res_in.halt       = 1'b1;
                  res_in.entry_hits = ram_rdata.hits + 32'd1;
                  res_in.total_hits = global_ff + 32'd1;
                  res_in.hit_value  = val_ff;
                  res_in.hit_pc     = pc_ff;
                  state_in          = ST_DONE;
               end else begin
                  res_in.removed_count = 5'd1;
                  state_in             = ST_MOVE_RD;
               end
            end else if (scan_more) begin
               // next entry into the compare unit
               ram_re    = 1'b1;
               ram_raddr = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
               ev_in     = 1'b1;
               ev_idx_in = scan_ff[IDX_W-1:0];
            end else begin
               ev_in    = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_MOVE_RD: begin
            // fetch the last entry
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(total_ff - CNT_W'(1));
            state_in  = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // last entry fills the removed slot
            ram_we    = 1'b1;
            ram_waddr = ev_idx_ff;
            ram_wdata = ram_rdata;
            total_in  = total_ff - CNT_W'(1);
            state_in  = ST_DONE;
         end
         ST_GET: begin
            res_in.result_id      = ram_rdata.ident;
            res_in.entry_address  = ram_rdata.start;
            res_in.entry_length   = ram_rdata.len;
            res_in.entry_on_read  = ram_rdata.rd;
            res_in.entry_on_write = ram_rdata.wr;
            res_in.entry_hits     = ram_rdata.hits;
            state_in              = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output handshake
   always_comb begin
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         next_id_ff   <= 16'd1;
         susp_ff      <= 8'd0;
         global_ff    <= 32'd0;
         scan_ff      <= '0;
         ev_ff        <= 1'b0;
         ev_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         next_id_ff   <= next_id_in;
         susp_ff      <= susp_in;
         global_ff    <= global_in;
         scan_ff      <= scan_in;
         ev_ff        <= ev_in;
         ev_idx_ff    <= ev_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_tuser);
         addr_ff    <= req_tdata[31:0];
         len_ff     <= req_tdata[63:32];
         rd_ff      <= req_tdata[64];
         wr_ff      <= req_tdata[65];
         wid_ff     <= req_tdata[81:66];
         idx_ff     <= req_tdata[85:82];
         isw_ff     <= req_tdata[89];
         val_ff     <= req_tdata[121:90];
         pc_ff      <= req_tdata[153:122];
         acc_end_ff <= req_tdata[31:0] + {29'd0, req_tdata[88:86]};
      end
   end

   // result and output registers
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.hit_pc, rsp_ff.hit_value, rsp_ff.total_hits,
                        rsp_ff.entry_hits, rsp_ff.entry_on_write, rsp_ff.entry_on_read,
                        rsp_ff.entry_length, rsp_ff.entry_address, rsp_ff.halt,
                        rsp_ff.removed_count, rsp_ff.result_id};

endmodule

`default_nettype wire

### sim/watchpoint_table_unit_test.sv
// self-checking testbench for the watchpoint table unit
`timescale 1ns / 1ps

module watchpoint_table_unit_test;
   import wtu_pkg::*;

   // operation codes the block treats as no-ops
   localparam logic [2:0] OP_UNDEF_6 = 3'd6;
   localparam logic [2:0] OP_UNDEF_7 = 3'd7;

   // handshake pacing of each stimulus phase
   typedef enum logic [1:0] {
      PACE_LIGHT_SEND,
      PACE_HEAVY_SEND,
      PACE_FULL_RATE
   } pace_type;

   // one request item with the pacing it travels under
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] address;
      logic [31:0] length;
      logic        on_read;
      logic        wr_enable;
      logic [15:0] watch_id;
      logic [3:0]  entry_index;
      logic [2:0]  access_size;
      logic        wr_access;
      logic [31:0] write_value;
      logic [31:0] pc;
      pace_type    mode;
   } watch_req_type;

   // expected result with the operation that caused it
   typedef struct packed {
      logic [2:0] op;
      result_type res;
   } watch_expect_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   watchpoint_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the watch table
   logic [31:0] shadow_start [TABLE_DEPTH];
   logic [31:0] shadow_len   [TABLE_DEPTH];
   logic [15:0] shadow_ident [TABLE_DEPTH];
   logic        shadow_rd    [TABLE_DEPTH];
   logic        shadow_wr    [TABLE_DEPTH];
   logic [31:0] shadow_hits  [TABLE_DEPTH];
   int unsigned shadow_count = 0;
   logic [15:0] shadow_next_id = 16'd1;
   int unsigned shadow_suspend = 0;
   logic [31:0] shadow_total_hits = '0;

   watch_req_type    pending_items [$];
   watch_expect_type expected_results [$];
   watch_req_type    bus_item;
   pace_type      gen_mode = PACE_LIGHT_SEND;
   pace_type      rsp_mode = PACE_LIGHT_SEND;
   logic [31:0]   aim_start [$];
   int unsigned   gen_sets = 0;
   int unsigned   fail_count = 0;
   int unsigned   result_count = 0;
   int unsigned   send_calm = 0;
   int unsigned   recv_calm = 0;
   int unsigned   hold_left = 0;
   int unsigned   hold_seen = 0;

   function automatic int unsigned idle_pct(pace_type m, logic sender);
      case (m)
         PACE_LIGHT_SEND: idle_pct = sender ? 38 : 84;
         PACE_HEAVY_SEND: idle_pct = sender ? 84 : 38;
         default:         idle_pct = 0;
      endcase
   endfunction

   // expected result of one item, updating the shadow table
   function automatic result_type predict_watch(watch_req_type r);
      result_type  res;
      int unsigned i;
      int unsigned last;
      logic [31:0] acc_end;
      logic [31:0] w_end;
      logic        done;
      res = '0;
      done = 1'b0;
      case (r.op)
         OP_SET: begin
            if (shadow_count >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_start[shadow_count] = r.address;
               shadow_len[shadow_count]   = (r.length == 32'd0) ? 32'd1 : r.length;
               shadow_ident[shadow_count] = shadow_next_id;
               shadow_rd[shadow_count]    = r.on_read;
               shadow_wr[shadow_count]    = r.wr_enable | ~r.on_read;
               shadow_hits[shadow_count]  = '0;
               shadow_count++;
               res.result_id = shadow_next_id;
               shadow_next_id = (shadow_next_id == 16'hFFFF) ? 16'd1 : shadow_next_id + 16'd1;
            end
         end
         OP_CLEAR: begin
            if (r.watch_id == 16'd0) begin
               res.removed_count = 5'(shadow_count);
               shadow_count = 0;
            end else begin
               for (i = 0; i < shadow_count && !done; i++) begin
                  if (shadow_ident[i] == r.watch_id) begin
                     // last entry fills the hole
                     last = shadow_count - 1;
                     shadow_start[i] = shadow_start[last];
                     shadow_len[i]   = shadow_len[last];
                     shadow_ident[i] = shadow_ident[last];
                     shadow_rd[i]    = shadow_rd[last];
                     shadow_wr[i]    = shadow_wr[last];
                     shadow_hits[i]  = shadow_hits[last];
                     shadow_count--;
                     res.removed_count = 5'd1;
                     done = 1'b1;
                  end
               end
            end
         end
         OP_CHECK: begin
            if (shadow_suspend == 0) begin
               acc_end = r.address + {29'd0, r.access_size};
               for (i = 0; i < shadow_count && !done; i++) begin
                  w_end = shadow_start[i] + shadow_len[i];
                  // direction first, then wrapped range overlap
                  if ((r.wr_access ? shadow_wr[i] : shadow_rd[i]) &&
                      !(acc_end <= shadow_start[i] || r.address >= w_end)) begin
                     shadow_hits[i]++;
                     shadow_total_hits++;
                     res.result_id  = shadow_ident[i];
                     res.halt       = 1'b1;
                     res.entry_hits = shadow_hits[i];
                     res.total_hits = shadow_total_hits;
                     res.hit_value  = r.write_value;
                     res.hit_pc     = r.pc;
                     done = 1'b1;
                  end
               end
            end
         end
         OP_SUSPEND: if (shadow_suspend < 255) shadow_suspend++;
         OP_RESUME:  if (shadow_suspend > 0) shadow_suspend--;
         OP_GET: begin
            if (r.entry_index >= shadow_count) begin
               res.status = STATUS_RANGE;
            end else begin
               res.result_id      = shadow_ident[r.entry_index];
               res.entry_address  = shadow_start[r.entry_index];
               res.entry_length   = shadow_len[r.entry_index];
               res.entry_on_read  = shadow_rd[r.entry_index];
               res.entry_on_write = shadow_wr[r.entry_index];
               res.entry_hits     = shadow_hits[r.entry_index];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR: %s", msg);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                              logic [2:0] op);
      if (got !== want)
         report_mismatch($sformatf("result %0d (op %0d) %s: got %h expected %h",
                                   result_count, op, name, got, want));
   endtask

   // item builders: every field random, then the ones that matter set
   function automatic watch_req_type noise_item(logic [2:0] code);
      watch_req_type it;
      it.op          = code;
      it.address     = $urandom;
      it.length      = $urandom;
      it.on_read     = 1'($urandom_range(0, 1));
      it.wr_enable   = 1'($urandom_range(0, 1));
      it.watch_id    = 16'($urandom);
      it.entry_index = 4'($urandom);
      it.access_size = 3'($urandom);
      it.wr_access   = 1'($urandom_range(0, 1));
      it.write_value = $urandom;
      it.pc          = $urandom;
      it.mode        = gen_mode;
      return it;
   endfunction

   task automatic add_plain(logic [2:0] code);
      pending_items.push_back(noise_item(code));
   endtask

   task automatic add_set(logic [31:0] a, logic [31:0] len, logic rd, logic wr);
      watch_req_type it;
      it = noise_item(OP_SET);
      it.address   = a;
      it.length    = len;
      it.on_read   = rd;
      it.wr_enable = wr;
      pending_items.push_back(it);
      aim_start.push_back(a);
      if (aim_start.size() > 16) void'(aim_start.pop_front());
      gen_sets++;
   endtask

   task automatic add_check(logic [31:0] a, logic [2:0] size, logic wr);
      watch_req_type it;
      it = noise_item(OP_CHECK);
      it.address     = a;
      it.access_size = size;
      it.wr_access   = wr;
      pending_items.push_back(it);
   endtask

   task automatic add_clear(logic [15:0] id);
      watch_req_type it;
      it = noise_item(OP_CLEAR);
      it.watch_id = id;
      pending_items.push_back(it);
   endtask

   task automatic add_get(logic [3:0] idx);
      watch_req_type it;
      it = noise_item(OP_GET);
      it.entry_index = idx;
      pending_items.push_back(it);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      watch_expect_type exp_item;
      logic          idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // item taken: predict its result
         if (req_tvalid && req_tready) begin
            exp_item.op  = bus_item.op;
            exp_item.res = predict_watch(bus_item);
            expected_results.push_back(exp_item);
            rsp_mode <= bus_item.mode;
         end
         if (send_calm > 0) send_calm--;
         else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(20, 100);
         // offer the next item unless idling
         if (!req_tvalid || req_tready) begin
            idle = 1'b0;
            if (pending_items.size() > 0)
               idle = (send_calm == 0) &&
                      ($urandom_range(0, 99) < idle_pct(pending_items[0].mode, 1'b1));
            if (pending_items.size() > 0 && !idle) begin
               bus_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= bus_item.op;
               req_tdata  <= {6'd0, bus_item.pc, bus_item.write_value, bus_item.wr_access,
                              bus_item.access_size, bus_item.entry_index, bus_item.watch_id,
                              bus_item.wr_enable, bus_item.on_read, bus_item.length,
                              bus_item.address};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-offs so the block backs up onto its input
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         hold_seen++;
         if (hold_seen == 350 || hold_seen == 1050) hold_left <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor and receiver pacing
   always @(posedge clock) begin : monitor
      result_type    got;
      watch_expect_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status         = rsp_tuser;
            got.result_id      = rsp_tdata[15:0];
            got.removed_count  = rsp_tdata[20:16];
            got.halt           = rsp_tdata[21];
            got.entry_address  = rsp_tdata[53:22];
            got.entry_length   = rsp_tdata[85:54];
            got.entry_on_read  = rsp_tdata[86];
            got.entry_on_write = rsp_tdata[87];
            got.entry_hits     = rsp_tdata[119:88];
            got.total_hits     = rsp_tdata[151:120];
            got.hit_value      = rsp_tdata[183:152];
            got.hit_pc         = rsp_tdata[215:184];
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         result_count));
            end else begin
               want = expected_results.pop_front();
               check_field("status", got.status, want.res.status, want.op);
               check_field("result_id", got.result_id, want.res.result_id, want.op);
               check_field("removed_count", got.removed_count, want.res.removed_count,
                           want.op);
               check_field("halt", got.halt, want.res.halt, want.op);
               check_field("entry_address", got.entry_address, want.res.entry_address,
                           want.op);
               check_field("entry_length", got.entry_length, want.res.entry_length,
                           want.op);
               check_field("entry_on_read", got.entry_on_read, want.res.entry_on_read,
                           want.op);
               check_field("entry_on_write", got.entry_on_write, want.res.entry_on_write,
                           want.op);
               check_field("entry_hits", got.entry_hits, want.res.entry_hits, want.op);
               check_field("total_hits", got.total_hits, want.res.total_hits, want.op);
               check_field("hit_value", got.hit_value, want.res.hit_value, want.op);
               check_field("hit_pc", got.hit_pc, want.res.hit_pc, want.op);
            end
            result_count++;
         end
         if (recv_calm > 0) recv_calm--;
         else if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(20, 100);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (recv_calm != 0) ||
                          ($urandom_range(0, 99) >= idle_pct(rsp_mode, 1'b0));
         end
      end
   end

   // watchdog
   initial begin
      #30_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned n;
      int unsigned k;
      int unsigned roll;
      int unsigned lo;
      logic [31:0] a;
      logic [31:0] len;
      logic [2:0]  size;

      // directed: empty table, default direction and length, wrapped ranges
      add_get(4'd0);
      add_clear(16'd0);
      add_check(32'h0000_0100, 3'd1, 1'b1);
      add_set(32'h0000_0100, 32'd0, 1'b0, 1'b0);
      add_set(32'hFFFF_FFF0, 32'h0000_0020, 1'b1, 1'b0);
      add_set(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
      add_get(4'd0);
      add_get(4'd3);
      add_get(4'd15);
      add_check(32'h0000_0100, 3'd1, 1'b1);
      add_check(32'hFFFF_FFFE, 3'd4, 1'b0);
      add_check(32'h0000_2004, 3'd7, 1'b1);
      add_check(32'h0000_0008, 3'd0, 1'b0);
      add_check(32'hFFFF_FFFF, 3'd1, 1'b0);
      // nested suspend, resume at zero
      add_plain(OP_SUSPEND);
      add_check(32'h0000_0100, 3'd1, 1'b1);
      add_plain(OP_SUSPEND);
      add_plain(OP_RESUME);
      add_check(32'h0000_0100, 3'd1, 1'b1);
      add_plain(OP_RESUME);
      add_plain(OP_RESUME);
      add_check(32'h0000_0100, 3'd1, 1'b1);
      // absent id, removal with move, undefined codes
      add_clear(16'h7777);
      add_clear(16'd1);
      add_get(4'd0);
      add_plain(OP_UNDEF_6);
      add_plain(OP_UNDEF_7);

      // random items under each pacing
      for (k = 0; k < 3; k++) begin
         if (k == 1) gen_mode = PACE_HEAVY_SEND;
         if (k == 2) gen_mode = PACE_FULL_RATE;
         for (n = 0; n < 400; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 24) begin
               case ($urandom_range(0, 5))
                  0: a = $urandom;
                  1: a = 32'hFFFF_FF00 + $urandom_range(0, 255);
                  default: a = 32'h1000 + $urandom_range(0, 4095);
               endcase
               case ($urandom_range(0, 9))
                  0: len = 32'd0;
                  1: len = $urandom;
                  2: len = 32'hFFFF_FFFF - $urandom_range(0, 15);
                  default: len = $urandom_range(1, 64);
               endcase
               add_set(a, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (roll < 32) begin
               lo = (gen_sets > 24) ? gen_sets - 24 : 1;
               if ($urandom_range(0, 19) == 0) add_clear(16'($urandom));
               else add_clear(16'($urandom_range(lo, gen_sets + 2)));
            end else if (roll < 35) begin
               add_clear(16'd0);
            end else if (roll < 73) begin
               if (aim_start.size() > 0 && $urandom_range(0, 9) < 7)
                  a = aim_start[$urandom_range(0, aim_start.size() - 1)]
                      + $urandom_range(0, 79) - 32'd8;
               else
                  a = $urandom;
               size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 4));
               add_check(a, size, 1'($urandom_range(0, 1)));
            end else if (roll < 77) begin
               add_plain(OP_SUSPEND);
            end else if (roll < 83) begin
               add_plain(OP_RESUME);
            end else if (roll < 97) begin
               add_get(4'($urandom_range(0, 15)));
            end else begin
               add_plain($urandom_range(0, 1) ? OP_UNDEF_6 : OP_UNDEF_7);
            end
         end
      end

      // suspend counter saturation: 260 in, 255 out must reach zero
      add_clear(16'd0);
      add_set(32'h0000_5000, 32'd8, 1'b1, 1'b1);
      for (n = 0; n < 260; n++) add_plain(OP_SUSPEND);
      add_check(32'h0000_5000, 3'd4, 1'b0);
      for (n = 0; n < 255; n++) add_plain(OP_RESUME);
      add_check(32'h0000_5000, 3'd4, 1'b1);

      // fill the table, once with a set too many
      for (n = 0; n < 2; n++) begin
         add_clear(16'd0);
         for (k = 0; k < ((n == 0) ? 17 : 16); k++)
            add_set($urandom, $urandom_range(1, 16), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         add_check(aim_start[$urandom_range(0, aim_start.size() - 1)],
                   3'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
         add_get(4'($urandom_range(0, 15)));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
